/* sv/attack_hold_decay_envelope_follower_assert.svh */
// Assertion macros for the attack/hold/decay envelope follower.
// Included by the checker; depends on nothing else.
`ifndef ATTACK_HOLD_DECAY_ENVELOPE_FOLLOWER_ASSERT_SVH
`define ATTACK_HOLD_DECAY_ENVELOPE_FOLLOWER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define AHD_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion that also holds during reset.
`define AHD_ASSERT_PLAIN(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* sv/ahd_env_pkg.sv */
// Shared constants, register codes and types of the envelope follower.
// Depends on nothing; used by the interfaces and every module.
package ahd_env_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned HOLD_BITS_DEF   = 24;

  localparam int unsigned ENV_BITS      = 32;
  localparam int unsigned OUT_BITS      = 16;
  localparam int unsigned STEP_BITS     = 32;
  localparam int unsigned HOLD_CFG_BITS = 24;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  // 1.0 in unsigned Q1.31, and the same value in the reported upper bits.
  localparam logic [ENV_BITS-1:0] ONE_Q31        = 32'h8000_0000;
  localparam logic [OUT_BITS-1:0] OUT_FULL_SCALE = 16'h8000;

  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_STEP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_STEP   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_SAMPLES = 2'd2;

  typedef struct packed {
    logic [STEP_BITS-1:0]     attack_step;
    logic [STEP_BITS-1:0]     decay_step;
    logic [HOLD_CFG_BITS-1:0] hold_samples;
  } ahd_cfg_t;

endpackage

/* sv/ahd_env_ifs.sv */
// Handshake interfaces of the envelope follower: sample in, result out, config write.
// Depends on ahd_env_pkg.
interface ahd_env_in_if import ahd_env_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ahd_env_out_if import ahd_env_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] envelope_out;
  logic                holding;

  modport source (output valid, output envelope_out, output holding, input ready);
  modport sink (input valid, input envelope_out, input holding, output ready);
endinterface

interface ahd_env_cfg_if import ahd_env_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/attack_hold_decay_envelope_follower.sv */
// Top level of the attack/hold/decay envelope follower.
// Depends on ahd_env_pkg, ahd_env_ifs, ahd_env_cfg_regs and ahd_env_core.
//
//   port    direction  item carries
//   in_i    sink       sample (signed, SAMPLE_BITS)
//   out_o   source     envelope_out (16), holding (1)
//   cfg_i   sink       index (2), data (32)
//
// One item per cycle is taken while the result is not stalled; each item passes through
// the input register and the result register, with the update logic between them.
// Reset clears the envelope, the hold count, the configuration registers and the pipe.
// A stalled result holds the pipe; the input register still takes one more item if it is empty.
// Configuration writes are taken in every cycle.
module attack_hold_decay_envelope_follower import ahd_env_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned HOLD_BITS   = HOLD_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ahd_env_in_if.sink    in_i,
  ahd_env_out_if.source out_o,
  ahd_env_cfg_if.sink   cfg_i
);

  ahd_cfg_t cfg;

  ahd_env_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  ahd_env_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .HOLD_BITS   (HOLD_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .in_sample_i    (in_i.sample),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_envelope_o (out_o.envelope_out),
    .out_holding_o  (out_o.holding)
  );

endmodule

/* sv/ahd_env_cfg_regs.sv */
// Configuration registers: attack step, decay step and hold length.
// Depends on ahd_env_pkg.
module ahd_env_cfg_regs import ahd_env_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_valid_i,
  output logic                     wr_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  wr_index_i,
  input  logic [CFG_DATA_BITS-1:0] wr_data_i,
  output ahd_cfg_t                 cfg_o
);

  ahd_cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        REG_ATTACK_STEP:  cfg_q.attack_step  <= STEP_BITS'(wr_data_i);
        REG_DECAY_STEP:   cfg_q.decay_step   <= STEP_BITS'(wr_data_i);
        REG_HOLD_SAMPLES: cfg_q.hold_samples <= HOLD_CFG_BITS'(wr_data_i);
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

endmodule

/* sv/ahd_env_core.sv */
// Envelope datapath: input register, one stage of update logic, result register.
// Depends on ahd_env_pkg.
module ahd_env_core import ahd_env_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned HOLD_BITS   = HOLD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ahd_cfg_t                      cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [OUT_BITS-1:0]           out_envelope_o,
  output logic                          out_holding_o
);

  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   out_valid_q;
  logic [OUT_BITS-1:0]    out_env_q;
  logic                   out_hold_q;
  logic [ENV_BITS-1:0]    env_q, env_d, env_c;
  logic [HOLD_BITS-1:0]   hold_q, hold_d;
  logic                   holding_d;
  logic                   advance;
  logic [SAMPLE_BITS-1:0] mag_s;
  logic [ENV_BITS-1:0]    mag;
  logic [ENV_BITS:0]      rise_sum;

  // The whole pipe moves when the result register is free or being emptied.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= $unsigned(in_sample_i);
    end
  end

  // The negation of the most negative sample wraps to the sign bit alone,
  // which is exactly full scale once shifted into Q1.31.
  assign mag_s    = s1_sample_q[SAMPLE_BITS-1] ? (~s1_sample_q + 1'b1) : s1_sample_q;
  assign mag      = {mag_s, {(ENV_BITS-SAMPLE_BITS){1'b0}}};
  assign rise_sum = {1'b0, env_q} + {1'b0, cfg_i.attack_step};

  always_comb begin
    env_d     = env_q;
    hold_d    = hold_q;
    holding_d = 1'b0;
    if (mag > env_q) begin
      if (cfg_i.attack_step == '0) begin
        env_d = mag;
      end else if (rise_sum > {1'b0, mag}) begin
        env_d = mag;
      end else begin
        env_d = rise_sum[ENV_BITS-1:0];
      end
      hold_d = HOLD_BITS'(cfg_i.hold_samples);
    end else if (mag < env_q) begin
      if (cfg_i.hold_samples != '0 && hold_q != '0) begin
        hold_d    = hold_q - 1'b1;
        holding_d = 1'b1;
      end else if (cfg_i.decay_step == '0) begin
        env_d = mag;
      end else if (cfg_i.decay_step >= env_q) begin
        env_d = '0;
      end else begin
        env_d = env_q - cfg_i.decay_step;
      end
    end
    env_c = (env_d > ONE_Q31) ? ONE_Q31 : env_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      env_q       <= '0;
      hold_q      <= '0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        env_q  <= env_c;
        hold_q <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_env_q  <= env_c[ENV_BITS-1 -: OUT_BITS];
      out_hold_q <= holding_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_envelope_o = out_env_q;
  assign out_holding_o  = out_hold_q;

endmodule

/* sv/ahd_env_checker.sv */
// Port-level checks of the envelope follower, bound to its top level.
// Depends on ahd_env_pkg and the assertion macro header.
`include "attack_hold_decay_envelope_follower_assert.svh"

module ahd_env_checker import ahd_env_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [OUT_BITS-1:0] out_envelope_i,
  input logic                out_holding_i
);

  // A result that waits must not change.
  `AHD_ASSERT_RST(a_out_stall_holds, clk_i, rst_ni,
                  out_valid_i && !out_ready_i |=>
                  out_valid_i && $stable(out_envelope_i) && $stable(out_holding_i))
  // The envelope never goes above full scale.
  `AHD_ASSERT_RST(a_env_in_range, clk_i, rst_ni, out_valid_i |-> out_envelope_i <= OUT_FULL_SCALE)
  // After an accepted item, the output shows a result, its own or an earlier one.
  `AHD_ASSERT_RST(a_result_latency, clk_i, rst_ni,
                  in_valid_i && in_ready_i |-> ##2 out_valid_i)
  // Reset leaves no result behind.
  `AHD_ASSERT_PLAIN(a_reset_empties, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind attack_hold_decay_envelope_follower ahd_env_checker u_ahd_env_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_envelope_i (out_o.envelope_out),
  .out_holding_i  (out_o.holding)
);

/* dv/testbench.sv */
// Self-checking testbench for the attack/hold/decay envelope follower.
// Depends on ahd_env_pkg, the handshake interfaces in ahd_env_ifs and the RTL top level.
// Samples are pushed through a randomly stalled driver and results are checked against a
// cycle-free envelope predictor kept in step with every accepted sample and register write.
module testbench import ahd_env_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int unsigned HOLD_W   = HOLD_BITS_DEF;
  localparam int FULL_SCALE_MAG    = 1 << (SAMPLE_W - 1);
  localparam int IDLE_PERCENT      = 29;
  localparam int MAX_REPORTS       = 10;
  localparam int HOLD_OFF_AFTER    = 700;
  localparam int HOLD_OFF_CYCLES   = 150;
  localparam int RANDOM_PER_PHASE  = 255;
  // Index 3 is not mapped to any register; writes there must leave the block alone.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] envelope_out;
    logic                holding;
  } envelope_result_t;

  typedef enum {SEG_BURST, SEG_TAIL, SEG_PLATEAU, SEG_SILENCE, SEG_NOISE} segment_kind_e;

  logic clk_i;
  logic rst_ni;

  ahd_env_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  ahd_env_out_if out_if ();
  ahd_env_cfg_if cfg_if ();

  attack_hold_decay_envelope_follower #(
    .SAMPLE_BITS(SAMPLE_W),
    .HOLD_BITS  (HOLD_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Predictor state and its copy of the registers.
  logic [ENV_BITS-1:0]      env_level;
  logic [HOLD_W-1:0]        hold_left;
  logic [STEP_BITS-1:0]     attack_now;
  logic [STEP_BITS-1:0]     decay_now;
  logic [HOLD_CFG_BITS-1:0] hold_now;

  sample_t          sample_queue[$];
  envelope_result_t envelope_due[$];

  int  n_pushed;
  int  n_accepted;
  int  n_checked;
  int  n_mismatch;
  bit  steady;
  bit  rx_hold;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic envelope_result_t follow_envelope(input sample_t s);
    int               v;
    logic [63:0]      mag;
    logic [63:0]      lvl;
    envelope_result_t r;
    v = s;
    if (v < 0) begin
      v = -v;
    end
    mag = 64'(v) << (ENV_BITS - SAMPLE_W);
    lvl = 64'(env_level);
    r.holding = 1'b0;
    if (mag > lvl) begin
      if (attack_now == '0) begin
        lvl = mag;
      end else begin
        lvl = lvl + 64'(attack_now);
        if (lvl > mag) begin
          lvl = mag;
        end
      end
      hold_left = hold_now[HOLD_W-1:0];
    end else if (mag < lvl) begin
      // A pending count is only spent while the hold register is nonzero.
      if (hold_now != '0 && hold_left != '0) begin
        hold_left = hold_left - 1'b1;
        r.holding = 1'b1;
      end else if (decay_now == '0) begin
        lvl = mag;
      end else if (64'(decay_now) >= lvl) begin
        lvl = '0;
      end else begin
        lvl = lvl - 64'(decay_now);
      end
    end
    if (lvl > 64'(ONE_Q31)) begin
      lvl = 64'(ONE_Q31);
    end
    env_level      = lvl[ENV_BITS-1:0];
    r.envelope_out = lvl[ENV_BITS-1:ENV_BITS-OUT_BITS];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) begin
      $display("%0t: result %0d: %s", $realtime, n_checked, what);
    end
  endtask

  // Sample driver: predicts on every accepted item, then offers the next one.
  always @(posedge clk_i) begin : sample_drive
    bit offer;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        envelope_due.push_back(follow_envelope(in_if.sample));
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        offer = sample_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT);
        in_if.valid <= offer;
        if (offer) begin
          in_if.sample <= sample_queue.pop_front();
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i) begin : result_check
    envelope_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (envelope_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result envelope_out=%0d holding=%0b",
                                  out_if.envelope_out, out_if.holding));
      end else begin
        want = envelope_due.pop_front();
        if (out_if.envelope_out !== want.envelope_out || out_if.holding !== want.holding) begin
          report_mismatch($sformatf("envelope_out exp %0d got %0d, holding exp %0b got %0b",
                                    want.envelope_out, out_if.envelope_out,
                                    want.holding, out_if.holding));
        end
        n_checked++;
      end
    end
    out_if.ready <= !rx_hold && (steady || $urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) begin
      @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_ATTACK_STEP:  attack_now = data;
      REG_DECAY_STEP:   decay_now = data;
      REG_HOLD_SAMPLES: hold_now = data[HOLD_CFG_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] atk, input logic [31:0] dcy,
                                input logic [31:0] hld);
    write_reg(REG_ATTACK_STEP, atk);
    write_reg(REG_DECAY_STEP, dcy);
    write_reg(REG_HOLD_SAMPLES, hld);
  endtask

  task automatic queue_sample(input sample_t s);
    sample_queue.push_back(s);
    n_pushed++;
  endtask

  // The most negative code doubles as a magnitude of full scale, so m up to 2^15 is fine.
  function automatic sample_t shaped_sample(input int hi, input int lo);
    int m;
    m = $urandom_range(hi, lo);
    return $urandom_range(1) ? sample_t'(-m) : sample_t'(m);
  endfunction

  // Random segments of loud bursts, quiet tails, plateaus, silence and noise make the envelope climb, hold and decay.
  task automatic add_segments(input int n_items);
    int            added;
    int            len;
    int            peak;
    int            pick;
    segment_kind_e kind;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        kind = SEG_BURST;
      end else if (pick < 68) begin
        kind = SEG_TAIL;
      end else if (pick < 80) begin
        kind = SEG_PLATEAU;
      end else if (pick < 90) begin
        kind = SEG_SILENCE;
      end else begin
        kind = SEG_NOISE;
      end
      len  = (kind == SEG_TAIL) ? $urandom_range(90, 10) : $urandom_range(40, 3);
      peak = ($urandom_range(7) == 0) ? FULL_SCALE_MAG : $urandom_range(FULL_SCALE_MAG);
      for (int k = 0; k < len && added < n_items; k++) begin
        case (kind)
          SEG_BURST:   queue_sample(shaped_sample(peak, peak / 2));
          SEG_TAIL:    queue_sample(shaped_sample(200, 0));
          SEG_PLATEAU: queue_sample(shaped_sample(peak, peak));
          SEG_SILENCE: queue_sample('0);
          default:     queue_sample(sample_t'($urandom));
        endcase
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (n_checked != n_pushed) begin
      @(posedge clk_i);
    end
  endtask

  task automatic random_phase(input logic [31:0] atk, input logic [31:0] dcy,
                              input logic [31:0] hld, input bit no_gaps);
    apply_settings(atk, dcy, hld);
    steady <= no_gaps;
    add_segments(RANDOM_PER_PHASE);
    wait_drained();
    steady <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    steady        = 1'b0;
    rx_hold       = 1'b0;
    env_level     = '0;
    hold_left     = '0;
    attack_now    = '0;
    decay_now     = '0;
    hold_now      = '0;
    n_pushed      = 0;
    n_accepted    = 0;
    n_checked     = 0;
    n_mismatch    = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: instant attack and release, no hold; repeat values give equal magnitude.
    queue_sample(16'sd0);
    queue_sample(16'sd32767);
    queue_sample(16'sd32767);
    queue_sample(-16'sd32768);
    queue_sample(-16'sd1);
    queue_sample(16'sd1);
    queue_sample(16'sd0);
    wait_drained();

    // The write to the unmapped index must change nothing; the hold load is truncated.
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    apply_settings(ONE_Q31, ONE_Q31, 32'hFFFF_FFFF);
    queue_sample(-16'sd32768);
    queue_sample(16'sd0);
    queue_sample(16'sd0);
    queue_sample(16'sd0);
    wait_drained();

    // Hold cleared while a large count is pending: decay goes ahead, the count stays.
    write_reg(REG_HOLD_SAMPLES, '0);
    queue_sample(16'sd0);
    queue_sample(16'sd16384);
    queue_sample(16'sd0);
    wait_drained();

    apply_settings(32'd1, 32'd1, 32'd5);
    queue_sample(16'sd32767);
    queue_sample(16'sd16384);
    queue_sample(16'sd16384);
    queue_sample(-16'sd16384);
    queue_sample(16'sd8192);
    queue_sample(16'sd8192);
    wait_drained();

    random_phase($urandom_range(1 << 26, 1 << 20), $urandom_range(1 << 27, 1 << 22),
                 $urandom_range(16), 1'b0);
    random_phase($urandom_range(1 << 26, 1 << 20), $urandom_range(1 << 27, 1 << 22),
                 $urandom_range(16), 1'b1);
    random_phase('0, $urandom_range(1 << 27, 1 << 22), $urandom_range(8), 1'b0);
    random_phase($urandom_range(1 << 27, 1 << 20), '0, $urandom_range(20), 1'b0);
    random_phase(ONE_Q31, 32'd1, '0, 1'b0);
    random_phase($urandom_range(ONE_Q31), $urandom_range(ONE_Q31),
                 $urandom_range(3) == 0 ? $urandom : $urandom_range(32), 1'b0);

    repeat (10) @(posedge clk_i);
    if (n_mismatch == 0 && envelope_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Long receiver stall while samples keep coming, so the pipe fills and backs up.
  initial begin
    while (n_accepted < HOLD_OFF_AFTER) begin
      @(posedge clk_i);
    end
    rx_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
